// ===== rtl/core/rvb_pkg.sv =====
// Shared constants, types and fixed-point helpers of the stereo reverb.
`default_nettype none
package rvb_pkg;
    localparam int SW = 24;
    localparam int AW = 44;
    localparam int PW = 11;
    localparam int COMB_N = 4;
    localparam int AP_N = 2;
    localparam int CW = 17;
    localparam int MAX_LEN = 2048;
    localparam int CLR_W = 14;

    localparam logic [CW-1:0] ONE_Q16 = 17'd65536;
    localparam logic [17:0] FB_SCALE = 18'd45875;
    localparam logic [17:0] FB_BASE = 18'd18350;
    localparam logic [CW-1:0] RST_DAMP = 17'd65536;
    localparam logic [CW-1:0] RST_WET = 17'd19661;

    localparam logic [1:0] REG_ENABLED = 2'd0;
    localparam logic [1:0] REG_ROOM = 2'd1;
    localparam logic [1:0] REG_DAMP = 2'd2;
    localparam logic [1:0] REG_WET = 2'd3;

    localparam logic signed [AW-1:0] SW_HI = 44'sd8388607;
    localparam logic signed [AW-1:0] SW_LO = -44'sd8388608;
    localparam logic signed [AW-1:0] S16_HI = 44'sd32767;
    localparam logic signed [AW-1:0] S16_LO = -44'sd32768;

    localparam logic [PW-1:0] COMB_BASE [COMB_N] = '{11'd1557, 11'd1617, 11'd1491, 11'd1422};
    localparam logic [PW-1:0] AP_BASE [AP_N] = '{11'd225, 11'd341};
    localparam logic [PW-1:0] COMB_EXTRA = 11'd23;
    localparam logic [PW-1:0] AP_EXTRA = 11'd7;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FB0, S_FB1, S_CRD, S_CMA, S_CMB, S_CMC, S_CMD, S_CWR,
        S_SCL, S_ARD, S_AWR, S_MXA, S_MXB, S_MXC, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic add;
    } t_mac_ctl;

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v;
        if (v > SW_HI) t = SW_HI;
        if (v < SW_LO) t = SW_LO;
        return t[SW-1:0];
    endfunction

    function automatic logic signed [15:0] sat_16(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v;
        if (v > S16_HI) t = S16_HI;
        if (v < S16_LO) t = S16_LO;
        return t[15:0];
    endfunction

    function automatic logic signed [AW-1:0] rnd16(input logic signed [AW-1:0] v);
        return (v + AW'(64'sd32768)) >>> 16;
    endfunction

    function automatic logic signed [AW-1:0] rnd24(input logic signed [AW-1:0] v);
        return (v + AW'(64'sd8388608)) >>> 24;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/stereo_comb_allpass_reverb_top.sv =====
// Top level of the stereo damped-comb and allpass reverb.
// One stereo pair is taken at a time; an enabled pair is processed on the single
// shared multiplier and the one-port delay memories in steps: the feedback coefficient,
// then per channel each comb, the scale, each allpass and the mix, then the output
// load. A disabled pair goes straight from idle to the output load. After reset the
// delay memories are swept to zero, during which no sample is taken; configuration
// writes are always accepted. Coefficients are Q1.16 with values above 65536 held
// at 65536.
`default_nettype none
module stereo_comb_allpass_reverb_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // left_in[15:0], right_in[31:16]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // left_out[15:0], right_out[31:16]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    import rvb_pkg::*;

    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    logic r_en;
    logic [CW-1:0] r_room, r_damp, r_wet, cfg_clamped;
    logic r_byp;
    logic signed [15:0] r_l, r_r, r_ol, r_or;
    logic r_ovalid;
    logic [31:0] r_odata;
    logic r_ch;
    logic [1:0] r_idx;
    logic [PW-1:0] r_cpos [2*COMB_N];
    logic [PW-1:0] r_apos [2*AP_N];
    logic signed [SW-1:0] r_lp [2*COMB_N];
    logic [17:0] r_fb;
    logic signed [SW-1:0] r_y, r_lpv, r_w, r_crd, r_ard;
    logic signed [SW+1:0] r_sum;
    logic [2:0] cline;
    logic [1:0] aline;
    logic [PW-1:0] clen, alen, cpos, apos;
    logic signed [SW-1:0] dry, c_wd, a_wd, lp_new;
    logic [CLR_W-1:0] c_addr;
    logic [CLR_W-2:0] a_addr;
    logic c_we, a_we;
    logic in_xfer, done_go;
    t_mac_ctl mac_ctl;
    logic signed [SW:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [AW-1:0] acc;
    logic signed [SW-1:0] comb_mem [2**CLR_W];
    logic signed [SW-1:0] ap_mem [2**(CLR_W-1)];

    rvb_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign done_go = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = r_odata;
    assign cfg_clamped = (i_cfg_data > ONE_Q16) ? ONE_Q16 : i_cfg_data;

    assign cline = {r_ch, r_idx};
    assign aline = {r_ch, r_idx[0]};
    assign cpos = r_cpos[cline];
    assign apos = r_apos[aline];
    assign clen = COMB_BASE[r_idx] + (r_ch ? COMB_EXTRA : '0);
    assign alen = AP_BASE[r_idx[0]] + (r_ch ? AP_EXTRA : '0);
    assign dry = r_ch ? {r_r, 8'd0} : {r_l, 8'd0};
    assign lp_new = sat_sw(rnd16(acc));
    assign c_wd = sat_sw(AW'(dry) + rnd16(acc));
    assign a_wd = sat_sw(AW'(r_w) + ((AW'(r_ard) + AW'(1)) >>> 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE:  if (in_xfer) n_state = r_en ? S_FB0 : S_DONE;
            S_FB0:   n_state = S_FB1;
            S_FB1:   n_state = S_CRD;
            S_CRD:   n_state = S_CMA;
            S_CMA:   n_state = S_CMB;
            S_CMB:   n_state = S_CMC;
            S_CMC:   n_state = S_CMD;
            S_CMD:   n_state = S_CWR;
            S_CWR:   n_state = (&r_idx) ? S_SCL : S_CRD;
            S_SCL:   n_state = S_ARD;
            S_ARD:   n_state = S_AWR;
            S_AWR:   n_state = r_idx[0] ? S_MXA : S_ARD;
            S_MXA:   n_state = S_MXB;
            S_MXB:   n_state = S_MXC;
            S_MXC:   n_state = r_ch ? S_DONE : S_CRD;
            S_DONE:  if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl = '0;
        mac_a = '0;
        mac_b = '0;
        c_we = 1'b0;
        a_we = 1'b0;
        c_addr = {cline, cpos};
        a_addr = {aline, apos};
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                a_we = 1'b1;
                c_addr = r_clr;
                a_addr = r_clr[CLR_W-2:0];
            end
            S_FB0: begin
                mac_ctl.load = 1'b1;
                mac_a = (SW+1)'(r_room);
                mac_b = FB_SCALE;
            end
            S_CMA: begin
                mac_ctl.load = 1'b1;
                mac_a = (SW+1)'(r_crd);
                mac_b = 18'(ONE_Q16 - r_damp);
            end
            S_CMB: begin
                mac_ctl.add = 1'b1;
                mac_a = (SW+1)'(r_lp[cline]);
                mac_b = 18'(r_damp);
            end
            S_CMD: begin
                mac_ctl.load = 1'b1;
                mac_a = (SW+1)'(r_lpv);
                mac_b = r_fb;
            end
            S_CWR: c_we = 1'b1;
            S_AWR: a_we = 1'b1;
            S_MXA: begin
                mac_ctl.load = 1'b1;
                mac_a = (SW+1)'(dry);
                mac_b = 18'(ONE_Q16 - r_wet);
            end
            S_MXB: begin
                mac_ctl.add = 1'b1;
                mac_a = (SW+1)'(r_w);
                mac_b = 18'(r_wet);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) comb_mem[c_addr] <= (r_state == S_CLEAR) ? '0 : c_wd;
        r_crd <= comb_mem[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) ap_mem[a_addr] <= (r_state == S_CLEAR) ? '0 : a_wd;
        r_ard <= ap_mem[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_en <= 1'b0;
            r_room <= '0;
            r_damp <= RST_DAMP;
            r_wet <= RST_WET;
            r_ovalid <= 1'b0;
            r_ch <= 1'b0;
            r_idx <= '0;
            r_sum <= '0;
            for (int k = 0; k < 2*COMB_N; k++) begin
                r_cpos[k] <= '0;
                r_lp[k] <= '0;
            end
            for (int k = 0; k < 2*AP_N; k++) begin
                r_apos[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ENABLED: r_en <= i_cfg_data[0];
                    REG_ROOM:    r_room <= cfg_clamped;
                    REG_DAMP:    r_damp <= cfg_clamped;
                    REG_WET:     r_wet <= cfg_clamped;
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_axis_tready) r_ovalid <= 1'b0;
            if (done_go) r_ovalid <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    r_ch <= 1'b0;
                    r_idx <= '0;
                end
                S_CWR: begin
                    r_cpos[cline] <= (cpos == clen - 1'b1) ? '0 : cpos + 1'b1;
                    r_sum <= r_sum + (SW+2)'(r_y);
                    r_idx <= r_idx + 1'b1;
                end
                S_CMC: r_lp[cline] <= lp_new;
                S_SCL: begin
                    r_sum <= '0;
                    r_idx <= '0;
                end
                S_AWR: begin
                    r_apos[aline] <= (apos == alen - 1'b1) ? '0 : apos + 1'b1;
                    r_idx <= r_idx[0] ? 2'd0 : 2'd1;
                end
                S_MXC: begin
                    r_ch <= ~r_ch;
                    r_idx <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_l <= i_s_axis_tdata[15:0];
            r_r <= i_s_axis_tdata[31:16];
            r_byp <= !r_en;
        end
        case (r_state)
            S_FB1: r_fb <= FB_BASE + 18'(rnd16(acc));
            S_CMA: r_y <= r_crd;
            S_CMC: r_lpv <= lp_new;
            S_SCL: r_w <= sat_sw((AW'(r_sum) + AW'(2)) >>> 2);
            S_AWR: r_w <= sat_sw(AW'(r_ard) - AW'(r_w));
            S_MXC: begin
                if (r_ch) r_or <= sat_16(rnd24(acc));
                else r_ol <= sat_16(rnd24(acc));
            end
            default: ;
        endcase
        if (done_go) r_odata <= r_byp ? {r_r, r_l} : {r_or, r_ol};
    end
endmodule
`default_nettype wire

// ===== rtl/core/rvb_mac.sv =====
// Shared signed multiply-accumulate unit with registered accumulator.
`default_nettype none
module rvb_mac (
    input  wire logic                               i_clk,
    input  wire rvb_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [rvb_pkg::SW:0]        i_a,
    input  wire logic signed [17:0]                 i_b,
    output logic signed [rvb_pkg::AW-1:0]           o_acc
);
    import rvb_pkg::*;

    logic signed [AW-1:0] prod;
    logic signed [AW-1:0] r_acc;

    assign prod = AW'(i_a * i_b);
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= prod;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + prod;
        end
    end
endmodule
`default_nettype wire

// ===== sim/reverb_checker.sv =====
// Checker for the stereo reverb: bit-true predictor of every output pair and comparison.
`default_nettype none
module reverb_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output int               o_fail,
    output int               o_pending
);
    import rvb_pkg::*;

    localparam int DEPTH = 2048;
    localparam longint SAT_HI = 64'sd8388607;
    localparam longint SAT_LO = -64'sd8388608;
    localparam int COMB_LEN [4] = '{1557, 1617, 1491, 1422};
    localparam int AP_LEN [2] = '{225, 341};

    typedef struct packed {
        logic signed [15:0] r_out;
        logic signed [15:0] l_out;
    } t_pair;

    t_pair pair_q[$];

    longint comb_mem [8*DEPTH];
    int     comb_pos [8];
    longint comb_lp [8];
    longint ap_mem [4*DEPTH];
    int     ap_pos [4];

    logic        rvb_on;
    int unsigned room_q16, damp_q16, wet_q16;
    int          fail_cnt;

    function automatic longint round_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint v, longint hi, longint lo);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic int unsigned coef(logic [16:0] v);
        return v > 17'd65536 ? 65536 : int'(v);
    endfunction

    function automatic longint reverb_channel(int ch, longint dry, longint fb);
        longint sum, w, y, lp;
        int line, len, at;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            line = ch * 4 + i;
            len = COMB_LEN[i] + (ch ? 23 : 0);
            at = line * DEPTH + comb_pos[line];
            y = comb_mem[at];
            lp = clip(round_shr(y * (65536 - longint'(damp_q16))
                      + comb_lp[line] * longint'(damp_q16), 16), SAT_HI, SAT_LO);
            comb_lp[line] = lp;
            comb_mem[at] = clip(dry + round_shr(lp * fb, 16), SAT_HI, SAT_LO);
            comb_pos[line] = (comb_pos[line] + 1 >= len) ? 0 : comb_pos[line] + 1;
            sum += y;
        end
        w = clip(round_shr(sum, 2), SAT_HI, SAT_LO);
        for (int i = 0; i < 2; i++) begin
            line = ch * 2 + i;
            len = AP_LEN[i] + (ch ? 7 : 0);
            at = line * DEPTH + ap_pos[line];
            y = ap_mem[at];
            ap_mem[at] = clip(w + round_shr(y, 1), SAT_HI, SAT_LO);
            w = clip(y - w, SAT_HI, SAT_LO);
            ap_pos[line] = (ap_pos[line] + 1 >= len) ? 0 : ap_pos[line] + 1;
        end
        return w;
    endfunction

    function automatic t_pair predict_pair(logic [31:0] din);
        t_pair  p;
        longint dl, dr, wl, wr, fb;
        if (!rvb_on) return din;
        fb = 18350 + round_shr(45875 * longint'(room_q16), 16);
        dl = longint'($signed(din[15:0])) * 256;
        dr = longint'($signed(din[31:16])) * 256;
        wl = reverb_channel(0, dl, fb);
        wr = reverb_channel(1, dr, fb);
        p.l_out = 16'(clip(round_shr(dl * (65536 - longint'(wet_q16))
                  + wl * longint'(wet_q16), 24), 32767, -32768));
        p.r_out = 16'(clip(round_shr(dr * (65536 - longint'(wet_q16))
                  + wr * longint'(wet_q16), 24), 32767, -32768));
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pair exp_p, got;
        if (!i_rst_n) begin
            foreach (comb_mem[k]) comb_mem[k] = 0;
            foreach (ap_mem[k]) ap_mem[k] = 0;
            foreach (comb_pos[k]) begin
                comb_pos[k] = 0;
                comb_lp[k] = 0;
            end
            foreach (ap_pos[k]) ap_pos[k] = 0;
            rvb_on = 1'b0;
            room_q16 = 0;
            damp_q16 = 65536;
            wet_q16 = 19661;
            fail_cnt = 0;
            pair_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ENABLED: rvb_on = i_cfg_data[0];
                    REG_ROOM:    room_q16 = coef(i_cfg_data);
                    REG_DAMP:    damp_q16 = coef(i_cfg_data);
                    REG_WET:     wet_q16 = coef(i_cfg_data);
                    default:     ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) pair_q.push_back(predict_pair(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (pair_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) $display("unexpected output pair %h", i_m_tdata);
                end else begin
                    exp_p = pair_q.pop_front();
                    if (got.l_out !== exp_p.l_out || got.r_out !== exp_p.r_out) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                     exp_p.l_out, got.l_out, exp_p.r_out, got.r_out);
                    end
                end
            end
        end
        o_fail <= fail_cnt;
        o_pending <= pair_q.size();
    end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the stereo reverb.
`default_nettype none
module tb;
    import rvb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    int          fail_cnt;
    int          pending;
    int          ready_pct;
    int          burst_left;
    int          pairs_sent;
    int          cfg_writes;

    stereo_comb_allpass_reverb_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    reverb_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail      (fail_cnt),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #4000000;
        $display("[stereo_comb_allpass_reverb_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) m_tready <= ($urandom_range(1, 100) <= ready_pct);

    task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        do @(posedge i_clk); while (!s_tready);
        pairs_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic configure(logic en, logic [16:0] room, logic [16:0] damp, logic [16:0] wet);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);
        cfg_write(REG_ROOM, room);
        cfg_write(REG_DAMP, damp);
        cfg_write(REG_WET, wet);
        cfg_write(REG_ENABLED, en);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample();
        int m;
        m = $urandom_range(0, 7);
        if (m < 2) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (m < 4) return 16'($signed($urandom_range(0, 2000)) - 1000);
        return 16'($urandom);
    endfunction

    task automatic run_phase(int n);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(16'sh0000, 16'shffff);
        send_pair(16'sh0001, 16'sh0000);
        for (int k = 0; k < n; k++) send_pair(pick_sample(), pick_sample());
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ENABLED;
        cfg_data = '0;
        ready_pct = 100;
        burst_left = 0;
        pairs_sent = 0;
        cfg_writes = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: bypass
        run_phase(10);
        ready_pct = 100;
        configure(1'b1, 17'd0, 17'd0, 17'd65536);
        run_phase(180);
        ready_pct = 60;
        configure(1'b1, 17'h1ffff, 17'd65536, 17'd0);
        run_phase(100);
        ready_pct = 25;
        configure(1'b0, 17'd40000, 17'd20000, 17'd30000);
        run_phase(30);
        ready_pct = 85;
        configure(1'b1, 17'd65536, 17'h1ffff, 17'h1ffff);
        run_phase(100);
        ready_pct = 50;
        configure(1'b1, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 65536)));
        run_phase(110);

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);
        $display("covered %0d stereo pairs over six register settings (%0d writes),",
                 pairs_sent, cfg_writes);
        $display("bypass, freeze, clamped coefficients and long echo tails included");
        if (fail_cnt == 0) begin
            $display("[stereo_comb_allpass_reverb_top] OK");
        end else begin
            $display("[stereo_comb_allpass_reverb_top] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
